// ===== hdl/ovng_pkg.sv =====
// Package for the octave value-noise generator: shared types, constants,
// register map, state encodings and the table-base helper function.
// No dependencies.
package ovng_pkg;

  localparam int unsigned DEF_MAX_OCTAVES   = 4;
  localparam int unsigned DEF_MAX_GRID_LOG2 = 10;
  localparam int unsigned DEF_SAMPLE_BITS   = 16;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_SEED        = 3'd0;
  localparam logic [2:0] REG_PERSISTENCE = 3'd1;
  localparam logic [2:0] REG_AMPLITUDE   = 3'd2;
  localparam logic [2:0] REG_OCTAVES     = 3'd3;
  localparam logic [2:0] REG_GRID_LOG2   = 3'd4;

  localparam logic [31:0] RST_SEED        = 32'd0;
  localparam logic [15:0] RST_PERSISTENCE = 16'd32768;
  localparam logic [15:0] RST_AMPLITUDE   = 16'd256;
  localparam logic [2:0]  RST_OCTAVES     = 3'd4;
  localparam logic [3:0]  RST_GRID_LOG2   = 4'd10;

  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_POINT    = 1'b1;

  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_INC  = 32'd12345;
  localparam logic [31:0] HASH_K1  = 32'd15731;
  localparam logic [31:0] HASH_K2  = 32'd789221;
  localparam logic [31:0] HASH_K3  = 32'd1376312589;

  typedef struct packed {
    logic        operation;
    logic [10:0] row;
    logic [10:0] column;
  } ovng_in_t;

  typedef struct packed {
    logic [31:0] noise_value;
    logic        tables_ready;
    logic        saturated;
  } ovng_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEN_START,
    ST_GEN_WAIT,
    ST_OCT,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_HOR,
    ST_VER,
    ST_RND,
    ST_TERM,
    ST_ACC,
    ST_DONE
  } ovng_state_e;

  typedef enum logic [2:0] {
    SMP_IDLE,
    SMP_SQ,
    SMP_MUL1,
    SMP_MUL2,
    SMP_FIN
  } ovng_step_e;

  // first table entry of octave o: 64 * (4^o - 1) / 3
  function automatic logic [31:0] octave_base(input logic [3:0] o);
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < o) begin
        acc = acc + (32'd64 << (2 * k));
      end
    end
    return acc;
  endfunction

endpackage

// ===== hdl/ovng_sample.sv =====
// Noise sample source: LCG step followed by the integer noise hash,
// one multiply per cycle. Depends on ovng_pkg.
module ovng_sample
  import ovng_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [31:0]            lcg_i,
  output logic                   done_o,
  output logic [31:0]            lcg_o,
  output logic [SAMPLE_BITS-1:0] sample_o
);

  localparam int unsigned SH = 31 - SAMPLE_BITS;
  localparam logic [32:0] RND = 33'(1) << (SH - 1);
  localparam logic [32:0] HALF = 33'h0_8000_0000;
  localparam logic [SAMPLE_BITS:0] SMAX = (SAMPLE_BITS+1)'((1 << SAMPLE_BITS) - 1);

  ovng_step_e step_q, step_d;
  logic       done_q;
  logic [31:0] lcg_q, n_q, sq_q, u_q, v_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [14:0] r;
  logic [27:0] n;
  logic [32:0] qw;
  logic [SAMPLE_BITS:0] q;

  assign r  = lcg_q[30:16];
  assign n  = {r, 13'd0} ^ {13'd0, r};
  assign qw = (HALF - {2'b0, v_q[30:0]} + RND) >> SH;
  assign q  = qw[SAMPLE_BITS:0];

  always_comb begin
    step_d = step_q;
    unique case (step_q)
      SMP_IDLE: if (start_i) step_d = SMP_SQ;
      SMP_SQ:   step_d = SMP_MUL1;
      SMP_MUL1: step_d = SMP_MUL2;
      SMP_MUL2: step_d = SMP_FIN;
      SMP_FIN:  step_d = SMP_IDLE;
      default:  step_d = SMP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= SMP_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == SMP_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (step_q)
      SMP_IDLE: if (start_i) lcg_q <= lcg_i * LCG_MUL + LCG_INC;
      SMP_SQ: begin
        n_q  <= 32'(n);
        sq_q <= 32'(n) * 32'(n);
      end
      SMP_MUL1: u_q <= sq_q * HASH_K1 + HASH_K2;
      SMP_MUL2: v_q <= n_q * u_q + HASH_K3;
      SMP_FIN:  sample_q <= (q > SMAX) ? SMAX[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign lcg_o    = lcg_q;
  assign sample_o = sample_q;

endmodule

// ===== hdl/octave_value_noise_generator.sv =====
// Octave value-noise generator, top level. Holds the register file, the
// sample table memory and the command sequencer. Depends on ovng_pkg, ovng_sample.
//
// A generate command fills 64*(4^n-1)/3 table entries for n effective octaves,
// each entry made in turn by the hash multiply chain in ovng_sample; the result
// transfer follows. A point command works octave by octave: four reads
// through the single table read port, then the interpolation and scaling
// multiplies one after another. A point before any generate skips the table.
// The table needs no clearing pass after reset. One command is worked at a time;
// a new one is taken while the previous result still waits at the output.
module octave_value_noise_generator
  import ovng_pkg::*;
#(
  parameter int unsigned MAX_OCTAVES   = DEF_MAX_OCTAVES,
  parameter int unsigned MAX_GRID_LOG2 = DEF_MAX_GRID_LOG2,
  parameter int unsigned SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ovng_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ovng_out_t          out_data_o
);

  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned DEPTH   = 64 * (((1 << (2 * MAX_OCTAVES)) - 1) / 3);
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned NW      = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned WW      = MAX_GRID_LOG2 - 2;
  localparam int unsigned SW      = $clog2(MAX_GRID_LOG2 - 1);
  localparam int unsigned ZW      = MAX_OCTAVES + 2;
  localparam int unsigned TOP_W   = SB + WW;
  localparam int unsigned SUM_W   = SB + 2 * WW;
  localparam int unsigned COEF_W  = 33;
  localparam int unsigned TERM_W  = COEF_W + SB;
  localparam int unsigned TOT_W   = 32 + NW;

  // configuration
  logic [31:0] seed_q, lcg_q;
  logic [15:0] pers_q, amp_q;
  logic [2:0]  oct_cnt_q;
  logic [3:0]  grid_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    unique case (cfg_idx)
      REG_SEED:        prdata = seed_q;
      REG_PERSISTENCE: prdata = {16'd0, pers_q};
      REG_AMPLITUDE:   prdata = {16'd0, amp_q};
      REG_OCTAVES:     prdata = {29'd0, oct_cnt_q};
      REG_GRID_LOG2:   prdata = {28'd0, grid_q};
      default:         prdata = '0;
    endcase
  end

  // effective grid size and octave count
  logic [3:0] g_eff, n_tmp;
  logic [NW-1:0] n_eff;
  always_comb begin
    if (grid_q < 4'd3) g_eff = 4'd3;
    else if (grid_q > 4'(MAX_GRID_LOG2)) g_eff = 4'(MAX_GRID_LOG2);
    else g_eff = grid_q;
    n_tmp = (oct_cnt_q == 3'd0) ? 4'd1 : {1'b0, oct_cnt_q};
    if (n_tmp > g_eff - 4'd2) n_tmp = g_eff - 4'd2;
    if (n_tmp > 4'(MAX_OCTAVES)) n_tmp = 4'(MAX_OCTAVES);
    n_eff = NW'(n_tmp);
  end

  ovng_state_e state_q, state_d;
  logic        tables_valid_q;
  logic        out_valid_q;
  ovng_out_t   out_q;
  logic        in_acc, out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sample source
  logic              smp_start, smp_done;
  logic [31:0]       smp_lcg;
  logic [SB-1:0]     smp_val;

  ovng_sample #(.SAMPLE_BITS(SAMPLE_BITS)) u_sample (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (smp_start),
    .lcg_i   (lcg_q),
    .done_o  (smp_done),
    .lcg_o   (smp_lcg),
    .sample_o(smp_val)
  );

  // command datapath registers
  logic [CW-1:0]   gen_cnt_q, gen_end;
  logic [NW-1:0]   oct_q;
  logic [10:0]     row_q, col_q;
  logic [16:0]     p_q;
  logic [TOT_W-1:0] total_q;
  logic [SW-1:0]   s_q;
  logic [WW-1:0]   fx_q, fz_q, wmx_q, wmz_q;
  logic [ZW-1:0]   z0_q, z1_q, x0_q, x1_q;
  logic [AW-1:0]   base_q;
  logic [COEF_W-1:0] coef_q;
  logic [SB-1:0]   a_q, b_q, c_q, d_q, interp_q;
  logic [TOP_W-1:0] top_q, bot_q;
  logic [SUM_W-1:0] sum_q;
  logic [TERM_W-1:0] term_q;
  logic            last_oct;

  assign gen_end  = CW'(octave_base(4'(n_eff)));
  assign last_oct = (oct_q + NW'(1) == n_eff);

  // per-octave geometry
  logic [SW-1:0] s_c;
  logic [WW-1:0] w_c, fx_c, fz_c;
  logic [ZW-1:0] msk_c, z0_c, x0_c;
  assign s_c   = SW'(g_eff - 4'd3 - 4'(oct_q));
  assign w_c   = WW'(1) << s_c;
  assign fx_c  = WW'(col_q) & (w_c - WW'(1));
  assign fz_c  = WW'(row_q) & (w_c - WW'(1));
  // the largest table wraps the shift to zero, leaving an all-ones mask
  assign msk_c = (ZW'(8) << oct_q) - ZW'(1);
  assign z0_c  = ZW'(row_q >> s_c) & msk_c;
  assign x0_c  = ZW'(col_q >> s_c) & msk_c;

  // table memory
  logic [SB-1:0] mem_q [DEPTH];
  logic [SB-1:0] rdata_q;
  logic [AW-1:0] rd_addr;
  logic [ZW-1:0] zsel, xsel;
  logic          mem_we;

  assign mem_we = (state_q == ST_GEN_WAIT) && smp_done;

  always_comb begin
    zsel = z0_q;
    xsel = x0_q;
    unique case (state_q)
      ST_RD1:  xsel = x1_q;
      ST_RD2:  zsel = z1_q;
      ST_RD3: begin
        zsel = z1_q;
        xsel = x1_q;
      end
      default: ;
    endcase
  end
  assign rd_addr = base_q + (AW'(zsel) << (oct_q + NW'(3))) + AW'(xsel);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[gen_cnt_q[AW-1:0]] <= smp_val;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_addr];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    smp_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.operation == OP_GENERATE) state_d = ST_GEN_START;
          else if (!tables_valid_q) state_d = ST_DONE;
          else state_d = ST_OCT;
        end
      end
      ST_GEN_START: begin
        smp_start = 1'b1;
        state_d   = ST_GEN_WAIT;
      end
      ST_GEN_WAIT: begin
        if (smp_done) begin
          state_d = (gen_cnt_q + CW'(1) == gen_end) ? ST_DONE : ST_GEN_START;
        end
      end
      ST_OCT:  state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_RD4;
      ST_RD4:  state_d = ST_HOR;
      ST_HOR:  state_d = ST_VER;
      ST_VER:  state_d = ST_RND;
      ST_RND:  state_d = ST_TERM;
      ST_TERM: state_d = ST_ACC;
      ST_ACC:  state_d = last_oct ? ST_DONE : ST_OCT;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      tables_valid_q <= 1'b0;
      out_valid_q    <= 1'b0;
      seed_q         <= RST_SEED;
      lcg_q          <= RST_SEED;
      pers_q         <= RST_PERSISTENCE;
      amp_q          <= RST_AMPLITUDE;
      oct_cnt_q      <= RST_OCTAVES;
      grid_q         <= RST_GRID_LOG2;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_SEED: begin
            seed_q <= pwdata;
            lcg_q  <= pwdata;
          end
          REG_PERSISTENCE: pers_q    <= pwdata[15:0];
          REG_AMPLITUDE:   amp_q     <= pwdata[15:0];
          REG_OCTAVES:     oct_cnt_q <= pwdata[2:0];
          REG_GRID_LOG2:   grid_q    <= pwdata[3:0];
          default: ;
        endcase
      end else if (mem_we) begin
        lcg_q <= smp_lcg;
      end
      if (mem_we && (gen_cnt_q + CW'(1) == gen_end)) tables_valid_q <= 1'b1;
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  logic [SUM_W:0]  rnd_c, shifted_c;
  logic [TERM_W:0] term_rnd;
  logic            sat_c;
  assign rnd_c     = ((SUM_W+1)'(1) << (2 * s_q)) >> 1;
  assign shifted_c = ({1'b0, sum_q} + rnd_c) >> (2 * s_q);
  assign term_rnd  = ({1'b0, term_q} + ((TERM_W+1)'(1) << (SB + 2))) >> (SB + 3);
  assign sat_c     = |total_q[TOT_W-1:32];

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          row_q     <= in_data_i.row;
          col_q     <= in_data_i.column;
          gen_cnt_q <= '0;
          oct_q     <= '0;
          total_q   <= '0;
          p_q       <= 17'h1_0000;
        end
      end
      ST_GEN_WAIT: if (smp_done) gen_cnt_q <= gen_cnt_q + CW'(1);
      ST_OCT: begin
        s_q    <= s_c;
        fx_q   <= fx_c;
        fz_q   <= fz_c;
        wmx_q  <= w_c - fx_c;
        wmz_q  <= w_c - fz_c;
        z0_q   <= z0_c;
        x0_q   <= x0_c;
        z1_q   <= (z0_c + ZW'(1)) & msk_c;
        x1_q   <= (x0_c + ZW'(1)) & msk_c;
        base_q <= AW'(octave_base(4'(oct_q)));
        coef_q <= COEF_W'(amp_q) * COEF_W'(p_q);
      end
      ST_RD1: a_q <= rdata_q;
      ST_RD2: b_q <= rdata_q;
      ST_RD3: c_q <= rdata_q;
      ST_RD4: d_q <= rdata_q;
      ST_HOR: begin
        top_q <= TOP_W'(a_q) * TOP_W'(wmx_q) + TOP_W'(b_q) * TOP_W'(fx_q);
        bot_q <= TOP_W'(c_q) * TOP_W'(wmx_q) + TOP_W'(d_q) * TOP_W'(fx_q);
      end
      ST_VER:  sum_q <= SUM_W'(top_q) * SUM_W'(wmz_q) + SUM_W'(bot_q) * SUM_W'(fz_q);
      ST_RND:  interp_q <= shifted_c[SB-1:0];
      ST_TERM: term_q <= TERM_W'(coef_q) * TERM_W'(interp_q);
      ST_ACC: begin
        total_q <= total_q + TOT_W'(term_rnd);
        p_q     <= 17'((34'(p_q) * 34'(pers_q) + 34'd32768) >> 16);
        oct_q   <= oct_q + NW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_q.noise_value  <= sat_c ? 32'hFFFF_FFFF : total_q[31:0];
          out_q.tables_ready <= tables_valid_q;
          out_q.saturated    <= sat_c;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ST_IDLE))
    else $error("sequencer idle after input transfer");

  a_sat_means_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |-> (out_data_o.noise_value == 32'hFFFF_FFFF))
    else $error("saturated result not at maximum");

  a_no_tables_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.tables_ready) |->
      (out_data_o.noise_value == 32'd0 && !out_data_o.saturated))
    else $error("nonzero result before tables generated");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (gen_cnt_q < CW'(DEPTH)))
    else $error("table write beyond depth");
`endif

endmodule

// ===== tb/sv/octave_value_noise_generator_tb.sv =====
// Self-checking testbench for octave_value_noise_generator: random generate and point
// commands under random idle and stall, with a built-in predictor of the noise sums.
// Depends on ovng_pkg and the octave_value_noise_generator RTL.
`timescale 1ns / 100ps

module octave_value_noise_generator_tb
  import ovng_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 150000;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned NUM_PHASES     = 12;
  localparam int unsigned PHASE_ITEMS    = 85;
  localparam int unsigned MEM_DEPTH      = 5440;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  ovng_in_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ovng_out_t          out_data_o;

  octave_value_noise_generator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and register mirror
  logic [15:0] sample_mem [0:MEM_DEPTH-1];
  logic [31:0] lcg_q;
  logic        gen_done;
  logic [15:0] cfg_pers;
  logic [15:0] cfg_amp;
  logic [2:0]  cfg_oct;
  logic [3:0]  cfg_grid;

  ovng_in_t  cmd_queue[$];
  ovng_out_t expected_noise[$];
  int        errors = 0;
  int        idle_count = 0;
  logic      in_xfer, out_xfer;

  function automatic int unsigned eff_grid(logic [3:0] g);
    if (g < 3) return 3;
    if (g > 10) return 10;
    return g;
  endfunction

  function automatic int unsigned eff_oct(logic [2:0] n, int unsigned g);
    int unsigned k;
    k = (n == 0) ? 1 : n;
    if (k > g - 2) k = g - 2;
    if (k > 4) k = 4;
    return k;
  endfunction

  function automatic int unsigned mem_base(int unsigned o);
    return 64 * (((1 << (2 * o)) - 1) / 3);
  endfunction

  function automatic logic [15:0] hash_sample();
    logic [31:0] r, n, t;
    logic [63:0] q;
    lcg_q = lcg_q * 32'd1103515245 + 32'd12345;
    r = {17'd0, lcg_q[30:16]};
    n = (r << 13) ^ r;
    t = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7FFF_FFFF;
    q = (64'h8000_0000 - {32'd0, t} + 64'd16384) >> 15;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [63:0] bilinear(int unsigned o, int unsigned g,
                                           logic [10:0] row, logic [10:0] col);
    int unsigned s, size, m, z0, z1, x0, x1, base;
    logic [63:0] w, fz, fx, a, b, c, d, sum;
    s = g - 3 - o;
    size = 8 << o;
    m = size - 1;
    w = 64'd1 << s;
    fz = row & (w - 1);
    fx = col & (w - 1);
    z0 = (row >> s) & m;
    z1 = (z0 + 1) & m;
    x0 = (col >> s) & m;
    x1 = (x0 + 1) & m;
    base = mem_base(o);
    a = sample_mem[base + z0 * size + x0];
    b = sample_mem[base + z0 * size + x1];
    c = sample_mem[base + z1 * size + x0];
    d = sample_mem[base + z1 * size + x1];
    sum = a * (w - fx) * (w - fz) + b * fx * (w - fz) + c * (w - fx) * fz + d * fx * fz;
    if (s == 0) return sum;
    return (sum + (64'd1 << (2 * s - 1))) >> (2 * s);
  endfunction

  function automatic void compute_noise_result(ovng_in_t cmd);
    ovng_out_t   res;
    int unsigned g, n;
    logic [63:0] p, coef, term, total;
    g = eff_grid(cfg_grid);
    n = eff_oct(cfg_oct, g);
    res = '0;
    if (cmd.operation == OP_GENERATE) begin
      for (int unsigned o = 0; o < n; o++) begin
        for (int unsigned i = 0; i < (64 << (2 * o)); i++) begin
          sample_mem[mem_base(o) + i] = hash_sample();
        end
      end
      gen_done = 1'b1;
    end else if (gen_done) begin
      p = 64'd65536;
      total = '0;
      for (int unsigned o = 0; o < n; o++) begin
        coef = {48'd0, cfg_amp} * p;
        term = coef * bilinear(o, g, cmd.row, cmd.column);
        total = total + ((term + (64'd1 << 18)) >> 19);
        p = (p * {48'd0, cfg_pers} + 64'd32768) >> 16;
      end
      if (total > 64'hFFFF_FFFF) begin
        res.noise_value = 32'hFFFF_FFFF;
        res.saturated = 1'b1;
      end else begin
        res.noise_value = total[31:0];
      end
    end
    res.tables_ready = gen_done;
    expected_noise.push_back(res);
  endfunction

  // driver
  int   in_gap = 0;
  logic in_no_idle = 1'b0;
  always @(posedge clk_i) begin
    logic hold, v;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      hold = in_valid_i && in_stall_o;
      if (in_valid_i && !in_stall_o) compute_noise_result(in_data_i);
      v = hold;
      if (!hold) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (cmd_queue.size() > 0) begin
          in_data_i <= cmd_queue.pop_front();
          v = 1'b1;
          if ($urandom_range(0, 39) == 0) in_no_idle = ~in_no_idle;
          in_gap = in_no_idle ? 0 : $urandom_range(0, 12);
        end
      end
      in_valid_i <= v;
    end
  end

  // monitor and checker
  int   out_wait = 0;
  logic out_no_idle = 1'b0;
  always @(posedge clk_i) begin
    ovng_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_noise.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer %h", $realtime, out_data_o);
        end else begin
          want = expected_noise.pop_front();
          if (out_data_o.noise_value !== want.noise_value) begin
            errors++;
            $display("%0t: noise_value expected %h actual %h", $realtime,
                     want.noise_value, out_data_o.noise_value);
          end
          if (out_data_o.tables_ready !== want.tables_ready) begin
            errors++;
            $display("%0t: tables_ready expected %b actual %b", $realtime,
                     want.tables_ready, out_data_o.tables_ready);
          end
          if (out_data_o.saturated !== want.saturated) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $realtime,
                     want.saturated, out_data_o.saturated);
          end
        end
        if ($urandom_range(0, 39) == 0) out_no_idle = ~out_no_idle;
        out_wait = out_no_idle ? 0 : $urandom_range(0, 12);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_stall_i <= (out_wait > 0);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    in_xfer = in_valid_i && !in_stall_o;
    out_xfer = out_valid_o && !out_stall_i;
    if (in_xfer || out_xfer || !rst_ni) idle_count = 0;
    else idle_count++;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("octave_value_noise_generator verification failed");
      $finish;
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SEED:        lcg_q = value;
      REG_PERSISTENCE: cfg_pers = value[15:0];
      REG_AMPLITUDE:   cfg_amp = value[15:0];
      REG_OCTAVES:     cfg_oct = value[2:0];
      REG_GRID_LOG2:   cfg_grid = value[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || in_valid_i || expected_noise.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic ovng_in_t make_cmd(logic op, logic [10:0] row, logic [10:0] col);
    ovng_in_t c;
    c.operation = op;
    c.row = row;
    c.column = col;
    return c;
  endfunction

  function automatic logic [10:0] pick_coord(int unsigned g);
    int unsigned lim;
    lim = 1 << g;
    case ($urandom_range(0, 7))
      0: return 11'd0;
      1: return lim[10:0];
      2: return 11'($urandom_range(0, 2047));
      3: return 11'($urandom_range(0, 2047));
      default: return 11'($urandom_range(0, lim));
    endcase
  endfunction

  initial begin
    int unsigned filled, g, n;
    logic [2:0]  oct;
    logic [3:0]  grd;
    logic [15:0] pers, amp;
    cfg_pers = RST_PERSISTENCE;
    cfg_amp = RST_AMPLITUDE;
    cfg_oct = RST_OCTAVES;
    cfg_grid = RST_GRID_LOG2;
    lcg_q = RST_SEED;
    gen_done = 1'b0;
    filled = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: points before any generate, then corners and wraps
    cmd_queue.push_back(make_cmd(OP_POINT, 11'd0, 11'd0));
    cmd_queue.push_back(make_cmd(OP_POINT, 11'd2047, 11'd2047));
    cmd_queue.push_back(make_cmd(OP_POINT, 11'd1024, 11'd5));
    cmd_queue.push_back(make_cmd(OP_GENERATE, 11'd2047, 11'd2047));
    filled = 4;
    cmd_queue.push_back(make_cmd(OP_POINT, 11'd0, 11'd0));
    cmd_queue.push_back(make_cmd(OP_POINT, 11'd1024, 11'd1024));
    cmd_queue.push_back(make_cmd(OP_POINT, 11'd0, 11'd1024));
    cmd_queue.push_back(make_cmd(OP_POINT, 11'd2047, 11'd2047));
    cmd_queue.push_back(make_cmd(OP_POINT, 11'd1023, 11'd1));
    cmd_queue.push_back(make_cmd(OP_POINT, 11'd1365, 11'd682));

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        pers = (p == 1) ? 16'hFFFF : (p == 2) ? 16'd0 : 16'($urandom);
        amp  = (p == 1) ? 16'hFFFF : (p == 2) ? 16'd0 :
               ($urandom_range(0, 2) == 0) ? 16'($urandom_range(49152, 65535)) : 16'($urandom);
        grd  = (p == 1) ? 4'd10 : (p == 2) ? 4'd3 : (p == 3) ? 4'd0 :
               (p == 4) ? 4'd15 : 4'($urandom_range(0, 15));
        oct  = (p == 1) ? 3'd7 : (p == 2) ? 3'd0 : 3'($urandom_range(0, 7));
        // keep four-octave generates rare, they walk the whole store
        if (p > 1 && p != 6 && eff_oct(oct, eff_grid(grd)) == 4) oct = 3'($urandom_range(1, 3));
        if (p == 1) apb_write(REG_SEED, 32'hFFFF_FFFF);
        else if ($urandom_range(0, 1) == 0) apb_write(REG_SEED, $urandom);
        apb_write(REG_PERSISTENCE, {16'd0, pers});
        apb_write(REG_AMPLITUDE, {16'd0, amp});
        apb_write(REG_OCTAVES, {29'd0, oct});
        apb_write(REG_GRID_LOG2, {28'd0, grd});
        g = eff_grid(grd);
        n = eff_oct(oct, g);
        cmd_queue.push_back(make_cmd(OP_GENERATE, 11'($urandom), 11'($urandom)));
        if (n > filled) filled = n;
      end else begin
        g = 10;
        n = 4;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (n <= 2 && $urandom_range(0, 49) == 0)
          cmd_queue.push_back(make_cmd(OP_GENERATE, 11'($urandom), 11'($urandom)));
        else
          cmd_queue.push_back(make_cmd(OP_POINT, pick_coord(g), pick_coord(g)));
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("octave_value_noise_generator verification clean");
    end else begin
      $display("octave_value_noise_generator verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ovng_pkg.sv
hdl/ovng_sample.sv
hdl/octave_value_noise_generator.sv
tb/sv/octave_value_noise_generator_tb.sv
